>>> rtl/fpha_pkg.sv
// ----------------------------------------------------------------------------
// fpha_pkg
// Shared types, codes and widths for the fit-policy hole allocator.
// ----------------------------------------------------------------------------
package fpha_pkg;

  localparam int SIZE_W = 12;
  localparam int ADDR_W = 11;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 9;
  localparam int POL_W  = 2;

  // cell control carries indexes and data at the widest supported configuration
  localparam int CELL_IDX_W  = 13;
  localparam int CELL_UNIT_W = 17;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FIT   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_BLOCK = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

  localparam logic [POL_W-1:0] POL_BEST  = 2'd0;
  localparam logic [POL_W-1:0] POL_WORST = 2'd1;
  localparam logic [POL_W-1:0] POL_FIRST = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_MEM    = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [SIZE_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] block_start;
    logic [SIZE_W-1:0] free_units;
    logic [CNT_W-1:0]  hole_count;
  } rsp_t;

  typedef struct packed {
    logic                   rot;
    logic                   rm;
    logic                   ins;
    logic [CELL_IDX_W-1:0]  sh_idx;
    logic                   wr;
    logic [CELL_IDX_W-1:0]  wr_idx;
    logic [CELL_UNIT_W-1:0] wr_start;
    logic [CELL_UNIT_W-1:0] wr_size;
  } cell_ctl_t;

endpackage

>>> rtl/fit_policy_hole_allocator_top.sv
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator_top
// Contiguous-region allocator with first, best or worst fit hole choice.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Allocate requests
// carve the chosen hole from its low end; free requests look up the block by
// start address and merge it with neighboring holes. Each request gives one
// result on out_result, marked by out_valid for one cycle; the receiver
// cannot stall it.
// Holes and blocks live in two rings of cells that rotate past compare logic
// at each ring head. Allocate rotates the hole ring once, then edits and
// outputs; free rotates the block ring, then the hole ring if the block is
// found. Allocate errors found up front go straight to the edit.
// One request at a time; busy stays high until the result is out.
// Configuration is over the APB port: fit_policy at 0x0, memory_units at
// 0x4. Writing memory_units drops every block and leaves one hole (none if 0).
// After reset the block sets up the initial hole in S_INIT before going idle.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator_top #(
  parameter int MEM_UNITS  = 2048,
  parameter int MAX_BLOCKS = 256
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  fpha_pkg::req_t in_request,
  output logic           out_valid,
  output fpha_pkg::rsp_t out_result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fpha_pkg::*;

  localparam int HN  = MAX_BLOCKS + 1;
  localparam int BN  = MAX_BLOCKS;
  localparam int DW  = $clog2(MEM_UNITS + 1);
  localparam int HCW = $clog2(HN + 1);
  localparam int BCW = $clog2(BN + 1);
  localparam int XW  = (DW > SIZE_W) ? DW : SIZE_W;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BSCAN = 3'd2;
  localparam logic [2:0] S_HSCAN = 3'd3;
  localparam logic [2:0] S_EDIT  = 3'd4;

  logic [2:0]       state_r;
  logic [POL_W-1:0] policy_r;
  logic [DW-1:0]    mem_r;
  logic [HCW-1:0]   hcnt_r;
  logic [BCW-1:0]   bcnt_r;
  logic [DW-1:0]    free_r;
  logic [HCW-1:0]   scan_r;
  logic             op_r;
  logic [XW-1:0]    req_r;
  logic [XW-1:0]    addr_r;
  logic [STAT_W-1:0] stat_r;
  logic             fnd_r;
  logic [HCW-1:0]   pidx_r;
  logic [DW-1:0]    pstart_r;
  logic [DW-1:0]    psize_r;
  logic [BCW-1:0]   bidx_r;
  logic [DW-1:0]    bsize_r;
  logic [2*DW-1:0]  last_r;
  logic             prv_ok_r;
  logic [2*DW-1:0]  prv_r;
  logic             abv_ok_r;
  logic [2*DW-1:0]  abv_r;
  logic             out_valid_r;
  rsp_t             out_r;

  logic [HCW-1:0]    hcnt_nxt;
  logic [BCW-1:0]    bcnt_nxt;
  logic [DW-1:0]     free_nxt;
  logic [STAT_W-1:0] fin_stat;

  cell_ctl_t hctl;
  cell_ctl_t bctl;
  logic [2*DW-1:0] hh;
  logic [2*DW-1:0] bh;

  fpha_row #(.N(HN), .DW(DW)) u_holes (.clk(clk), .ctl(hctl), .head(hh));
  fpha_row #(.N(BN), .DW(DW)) u_blocks (.clk(clk), .ctl(bctl), .head(bh));

  // head decode
  logic [XW-1:0] hst_x;
  logic [XW-1:0] hsz_x;
  logic          h_valid;
  logic          b_valid;
  logic          b_hit;
  logic          h_better;
  logic          scan_last_b;
  logic          scan_last_h;

  assign hst_x   = XW'(hh[2*DW-1:DW]);
  assign hsz_x   = XW'(hh[DW-1:0]);
  assign h_valid = scan_r < hcnt_r;
  assign b_valid = scan_r < HCW'(bcnt_r);
  assign b_hit   = b_valid && (XW'(bh[2*DW-1:DW]) == addr_r);
  assign scan_last_b = scan_r == HCW'(BN - 1);
  assign scan_last_h = scan_r == HCW'(HN - 1);
  assign h_better = h_valid && (hsz_x >= req_r) &&
                    (!fnd_r ||
                     ((policy_r == POL_BEST) && (hsz_x < XW'(psize_r))) ||
                     ((policy_r == POL_WORST) && (hsz_x > XW'(psize_r))));

  // merge tests for free
  logic [XW:0] prv_end;
  logic [XW:0] blk_end;
  logic        below;
  logic        above;

  assign prv_end = (XW+1)'(prv_r[2*DW-1:DW]) + (XW+1)'(prv_r[DW-1:0]);
  assign blk_end = (XW+1)'(addr_r) + (XW+1)'(bsize_r);
  assign below   = prv_ok_r && (prv_end == (XW+1)'(addr_r));
  assign above   = abv_ok_r && (blk_end == (XW+1)'(abv_r[2*DW-1:DW]));

  // ring control and edit results
  always_comb begin
    hctl     = '0;
    bctl     = '0;
    hcnt_nxt = hcnt_r;
    bcnt_nxt = bcnt_r;
    free_nxt = free_r;
    fin_stat = stat_r;
    if (stat_r == STAT_OK) begin
      if ((op_r == OP_ALLOC) && !fnd_r) fin_stat = STAT_NO_FIT;
      if ((op_r == OP_FREE) && !below && !above && (hcnt_r >= HCW'(HN))) begin
        fin_stat = STAT_FULL;
      end
    end
    case (state_r)
      S_INIT: begin
        hctl.wr      = 1'b1;
        hctl.wr_idx  = '0;
        hctl.wr_start = '0;
        hctl.wr_size = CELL_UNIT_W'(mem_r);
      end
      S_BSCAN: bctl.rot = 1'b1;
      S_HSCAN: hctl.rot = 1'b1;
      S_EDIT: begin
        if (fin_stat == STAT_OK) begin
          if (op_r == OP_ALLOC) begin
            if (XW'(psize_r) == req_r) begin
              hctl.rm     = 1'b1;
              hctl.sh_idx = CELL_IDX_W'(pidx_r);
              hcnt_nxt    = hcnt_r - 1'b1;
            end else begin
              hctl.wr       = 1'b1;
              hctl.wr_idx   = CELL_IDX_W'(pidx_r);
              hctl.wr_start = CELL_UNIT_W'(pstart_r + DW'(req_r));
              hctl.wr_size  = CELL_UNIT_W'(psize_r - DW'(req_r));
            end
            bctl.wr       = 1'b1;
            bctl.wr_idx   = CELL_IDX_W'(bcnt_r);
            bctl.wr_start = CELL_UNIT_W'(pstart_r);
            bctl.wr_size  = CELL_UNIT_W'(req_r);
            bcnt_nxt      = bcnt_r + 1'b1;
            free_nxt      = free_r - DW'(req_r);
          end else begin
            if (below && above) begin
              hctl.wr       = 1'b1;
              hctl.wr_idx   = CELL_IDX_W'(pidx_r - 1'b1);
              hctl.wr_start = CELL_UNIT_W'(prv_r[2*DW-1:DW]);
              hctl.wr_size  = CELL_UNIT_W'(prv_r[DW-1:0] + bsize_r + abv_r[DW-1:0]);
              hctl.rm       = 1'b1;
              hctl.sh_idx   = CELL_IDX_W'(pidx_r);
              hcnt_nxt      = hcnt_r - 1'b1;
            end else if (below) begin
              hctl.wr       = 1'b1;
              hctl.wr_idx   = CELL_IDX_W'(pidx_r - 1'b1);
              hctl.wr_start = CELL_UNIT_W'(prv_r[2*DW-1:DW]);
              hctl.wr_size  = CELL_UNIT_W'(prv_r[DW-1:0] + bsize_r);
            end else if (above) begin
              hctl.wr       = 1'b1;
              hctl.wr_idx   = CELL_IDX_W'(pidx_r);
              hctl.wr_start = CELL_UNIT_W'(addr_r);
              hctl.wr_size  = CELL_UNIT_W'(abv_r[DW-1:0] + bsize_r);
            end else begin
              hctl.ins      = 1'b1;
              hctl.sh_idx   = CELL_IDX_W'(pidx_r);
              hctl.wr       = 1'b1;
              hctl.wr_idx   = CELL_IDX_W'(pidx_r);
              hctl.wr_start = CELL_UNIT_W'(addr_r);
              hctl.wr_size  = CELL_UNIT_W'(bsize_r);
              hcnt_nxt      = hcnt_r + 1'b1;
            end
            // last block moves into the freed slot
            bctl.wr       = 1'b1;
            bctl.wr_idx   = CELL_IDX_W'(bidx_r);
            bctl.wr_start = CELL_UNIT_W'(last_r[2*DW-1:DW]);
            bctl.wr_size  = CELL_UNIT_W'(last_r[DW-1:0]);
            bcnt_nxt      = bcnt_r - 1'b1;
            free_nxt      = free_r + bsize_r;
          end
        end
      end
      default: ;
    endcase
  end

  // configuration decode
  logic          cfg_wr;
  logic [11:0]   mem_wv;
  logic [DW-1:0] mem_sat;

  assign cfg_wr  = psel && penable && pwrite;
  assign mem_wv  = pwdata[11:0];
  assign mem_sat = (32'(mem_wv) > 32'(MEM_UNITS)) ? DW'(MEM_UNITS) : DW'(mem_wv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      policy_r    <= POL_FIRST;
      mem_r       <= DW'(MEM_UNITS);
      hcnt_r      <= HCW'(1);
      bcnt_r      <= '0;
      free_r      <= DW'(MEM_UNITS);
      out_valid_r <= 1'b0;
      scan_r      <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: state_r <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            op_r     <= in_request.operation;
            req_r    <= XW'(in_request.request_size);
            addr_r   <= XW'(in_request.block_address);
            scan_r   <= '0;
            fnd_r    <= 1'b0;
            prv_ok_r <= 1'b0;
            abv_ok_r <= 1'b0;
            pidx_r   <= hcnt_r;
            stat_r   <= STAT_OK;
            if (in_request.operation == OP_FREE) begin
              state_r <= S_BSCAN;
            end else if (bcnt_r >= BCW'(BN)) begin
              stat_r  <= STAT_FULL;
              state_r <= S_EDIT;
            end else if (in_request.request_size == '0) begin
              stat_r  <= STAT_NO_FIT;
              state_r <= S_EDIT;
            end else begin
              state_r <= S_HSCAN;
            end
          end
        end
        S_BSCAN: begin
          if (b_hit && !fnd_r) begin
            fnd_r   <= 1'b1;
            bidx_r  <= BCW'(scan_r);
            bsize_r <= bh[DW-1:0];
          end
          if (b_valid && (scan_r == HCW'(bcnt_r - 1'b1))) last_r <= bh;
          if (scan_last_b) begin
            scan_r <= '0;
            if (fnd_r || b_hit) begin
              state_r <= S_HSCAN;
            end else begin
              stat_r  <= STAT_NO_BLOCK;
              state_r <= S_EDIT;
            end
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_HSCAN: begin
          if (op_r == OP_ALLOC) begin
            if (h_better) begin
              fnd_r    <= 1'b1;
              pidx_r   <= scan_r;
              pstart_r <= hh[2*DW-1:DW];
              psize_r  <= hh[DW-1:0];
            end
          end else begin
            if (h_valid && (hst_x <= addr_r)) begin
              prv_ok_r <= 1'b1;
              prv_r    <= hh;
            end
            if (h_valid && (hst_x > addr_r) && !abv_ok_r) begin
              abv_ok_r <= 1'b1;
              abv_r    <= hh;
              pidx_r   <= scan_r;
            end
          end
          if (scan_last_h) begin
            scan_r  <= '0;
            state_r <= S_EDIT;
          end else begin
            scan_r <= scan_r + 1'b1;
          end
        end
        S_EDIT: begin
          hcnt_r      <= hcnt_nxt;
          bcnt_r      <= bcnt_nxt;
          free_r      <= free_nxt;
          out_valid_r <= 1'b1;
          out_r.status      <= fin_stat;
          out_r.block_start <= (fin_stat != STAT_OK) ? '0 :
                               (op_r == OP_ALLOC) ? ADDR_W'(pstart_r) : ADDR_W'(addr_r);
          out_r.free_units  <= SIZE_W'(free_nxt);
          out_r.hole_count  <= CNT_W'(hcnt_nxt);
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_wr) begin
        if (paddr[2] == REG_POLICY) begin
          policy_r <= (pwdata[1:0] == 2'd3) ? POL_FIRST : pwdata[1:0];
        end else begin
          mem_r   <= mem_sat;
          hcnt_r  <= HCW'(mem_sat != '0);
          bcnt_r  <= '0;
          free_r  <= mem_sat;
          state_r <= S_INIT;
        end
      end
    end
  end

  assign busy       = state_r != S_IDLE;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == REG_MEM) ? 32'(mem_r) : 32'(policy_r);

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result.status != STAT_OK) |-> out_result.block_start == '0)
    else $error("error result carries an address");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !(psel && penable && pwrite) |=> busy)
    else $error("request not taken");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (hcnt_r <= HCW'(HN)) && (bcnt_r <= BCW'(BN)))
    else $error("table count overflow");

endmodule

>>> rtl/fpha_cell.sv
// ----------------------------------------------------------------------------
// fpha_cell
// One table entry (start, size). Rotates, shifts or is written by broadcast.
// ----------------------------------------------------------------------------
module fpha_cell #(
  parameter int IDX = 0,
  parameter int DW  = 12
) (
  input  logic                  clk,
  input  fpha_pkg::cell_ctl_t   ctl,
  input  logic [2*DW-1:0]       nxt_i,
  input  logic [2*DW-1:0]       prv_i,
  output logic [2*DW-1:0]       q
);
  import fpha_pkg::*;

  localparam logic [CELL_IDX_W-1:0] MY_IDX = CELL_IDX_W'(IDX);

  logic [2*DW-1:0] q_r;
  logic [2*DW-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.rot) begin
      q_nxt = nxt_i;
    end else begin
      if (ctl.rm && (MY_IDX >= ctl.sh_idx)) q_nxt = nxt_i;
      if (ctl.ins && (MY_IDX > ctl.sh_idx)) q_nxt = prv_i;
      if (ctl.wr && (MY_IDX == ctl.wr_idx)) begin
        q_nxt = {ctl.wr_start[DW-1:0], ctl.wr_size[DW-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> rtl/fpha_row.sv
// ----------------------------------------------------------------------------
// fpha_row
// Ring of table cells; entry 0 is the head seen by the scan logic.
// ----------------------------------------------------------------------------
module fpha_row #(
  parameter int N  = 4,
  parameter int DW = 12
) (
  input  logic                clk,
  input  fpha_pkg::cell_ctl_t ctl,
  output logic [2*DW-1:0]     head
);
  import fpha_pkg::*;

  logic [2*DW-1:0] q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [2*DW-1:0] nxt_d;
    logic [2*DW-1:0] prv_d;
    // last cell wraps to the head so a full rotation restores the table
    assign nxt_d = (i == N-1) ? q[0] : q[(i+1) % N];
    assign prv_d = (i == 0) ? q[0] : q[(i+N-1) % N];
    fpha_cell #(.IDX(i), .DW(DW)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .nxt_i (nxt_d),
      .prv_i (prv_d),
      .q     (q[i])
    );
  end

  assign head = q[0];

endmodule

>>> bench/tb_fit_policy_hole_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_fit_policy_hole_allocator_top
// Self-checking bench for the fit-policy hole allocator.
// ----------------------------------------------------------------------------
// A built-in allocator model tracks the hole and block tables and predicts
// every result. A directed list covers the edge cases. Random phases then run
// under each fit policy and several memory sizes, one of them filling the
// block table. Requests come with random gaps. Each phase begins with APB
// writes made while the block is idle.
// ----------------------------------------------------------------------------
module tb_fit_policy_hole_allocator_top;
  import fpha_pkg::*;

  localparam int MEM_MAX    = 2048;
  localparam int BLK_MAX    = 256;
  localparam int HOLE_MAX   = BLK_MAX + 1;
  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN_CYC  = 2 * BLK_MAX + 80;
  localparam logic [2:0] ADDR_POLICY = 3'd0;
  localparam logic [2:0] ADDR_MEM    = 3'd4;
  localparam int MIX_NORMAL = 0;
  localparam int MIX_FILL   = 1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        in_request = '0;
  logic        out_valid;
  rsp_t        out_result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fit_policy_hole_allocator_top #(.MEM_UNITS(MEM_MAX), .MAX_BLOCKS(BLK_MAX)) i_dut (
    .clk, .rst_n, .start, .busy, .in_request, .out_valid, .out_result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // allocator model state
  int hole_start [HOLE_MAX];
  int hole_size  [HOLE_MAX];
  int blk_start  [BLK_MAX];
  int blk_size   [BLK_MAX];
  int hole_n, blk_n;
  int policy, mem_units;

  req_t pend_q[$];
  rsp_t rsp_q[$];
  int   errors = 0;
  int   gap_left = 0;
  int   idle_cycles = 0;

  task automatic clear_memory();
    blk_n = 0;
    hole_n = (mem_units == 0) ? 0 : 1;
    hole_start[0] = 0;
    hole_size[0]  = mem_units;
  endtask

  task automatic drop_hole(input int idx);
    for (int k = idx; k < hole_n - 1; k++) begin
      hole_start[k] = hole_start[k+1];
      hole_size[k]  = hole_size[k+1];
    end
    hole_n--;
  endtask

  task automatic serve_request(input req_t r, output rsp_t o);
    int pick, sz, addr, b, p, bsz, total, st, where;
    bit below, above;
    st = int'(STAT_OK);
    where = 0;
    sz = int'(r.request_size);
    addr = int'(r.block_address);
    if (r.operation == OP_ALLOC) begin
      if (blk_n >= BLK_MAX) st = int'(STAT_FULL);
      else if (sz == 0) st = int'(STAT_NO_FIT);
      else begin
        pick = hole_n;
        for (int i = 0; i < hole_n; i++) begin
          if (hole_size[i] < sz) continue;
          if (policy == POL_BEST) begin
            if (pick == hole_n || hole_size[i] < hole_size[pick]) pick = i;
          end else if (policy == POL_WORST) begin
            if (pick == hole_n || hole_size[i] > hole_size[pick]) pick = i;
          end else begin
            pick = i;
            break;
          end
        end
        if (pick >= hole_n) st = int'(STAT_NO_FIT);
        else begin
          where = hole_start[pick];
          if (hole_size[pick] == sz) drop_hole(pick);
          else begin
            hole_start[pick] += sz;
            hole_size[pick]  -= sz;
          end
          blk_start[blk_n] = where;
          blk_size[blk_n]  = sz;
          blk_n++;
        end
      end
    end else begin
      b = 0;
      while (b < blk_n && blk_start[b] != addr) b++;
      if (b >= blk_n) st = int'(STAT_NO_BLOCK);
      else begin
        bsz = blk_size[b];
        p = 0;
        while (p < hole_n && hole_start[p] <= addr) p++;
        below = (p > 0) && (hole_start[p-1] + hole_size[p-1] == addr);
        above = (p < hole_n) && (addr + bsz == hole_start[p]);
        if (!below && !above && hole_n >= HOLE_MAX) st = int'(STAT_FULL);
        else begin
          if (below && above) begin
            hole_size[p-1] += bsz + hole_size[p];
            drop_hole(p);
          end else if (below) begin
            hole_size[p-1] += bsz;
          end else if (above) begin
            hole_start[p] = addr;
            hole_size[p] += bsz;
          end else begin
            for (int k = hole_n; k > p; k--) begin
              hole_start[k] = hole_start[k-1];
              hole_size[k]  = hole_size[k-1];
            end
            hole_start[p] = addr;
            hole_size[p]  = bsz;
            hole_n++;
          end
          blk_n--;
          blk_start[b] = blk_start[blk_n];
          blk_size[b]  = blk_size[blk_n];
          where = addr;
        end
      end
    end
    if (st != int'(STAT_OK)) where = 0;
    total = 0;
    for (int i = 0; i < hole_n; i++) total += hole_size[i];
    o.status      = STAT_W'(st);
    o.block_start = ADDR_W'(where);
    o.free_units  = SIZE_W'(total);
    o.hole_count  = CNT_W'(hole_n);
  endtask

  // request driver
  always @(posedge clk) begin
    rsp_t pred;
    if (rst_n) begin
      if (start && !busy) begin
        serve_request(in_request, pred);
        rsp_q.push_back(pred);
        gap_left = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0) gap_left = 0;
        if (gap_left == 0 && pend_q.size() > 0) begin
          in_request <= pend_q.pop_front();
          gap_left = $urandom_range(0, 13);
        end else begin
          start <= 1'b0;
        end
      end else if (!start) begin
        if (gap_left > 0) gap_left--;
        else if (pend_q.size() > 0) begin
          start <= 1'b1;
          in_request <= pend_q.pop_front();
        end
      end
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    rsp_t want;
    if (out_valid) begin
      if (rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_result);
      end else begin
        want = rsp_q.pop_front();
        if (out_result.status !== want.status ||
            out_result.block_start !== want.block_start ||
            out_result.free_units !== want.free_units ||
            out_result.hole_count !== want.hole_count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %p, got %p", want, out_result);
        end
      end
    end
    if (out_valid || (start && !busy)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_POLICY) begin
      policy = int'(d[1:0]);
      if (policy > POL_FIRST) policy = int'(POL_FIRST);
    end else begin
      mem_units = int'(d[11:0]);
      if (mem_units > MEM_MAX) mem_units = MEM_MAX;
      clear_memory();
    end
  endtask

  task automatic wait_idle();
    while (pend_q.size() > 0 || start || rsp_q.size() > 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  function automatic req_t mk_req(input logic op, input int sz, input int addr);
    req_t r;
    r.operation = op;
    r.request_size = SIZE_W'(sz);
    r.block_address = ADDR_W'(addr);
    return r;
  endfunction

  task automatic random_phase(input int n, input int mix);
    req_t r;
    int pct, sz;
    for (int i = 0; i < n; i++) begin
      while (pend_q.size() > 0) @(posedge clk);
      pct = $urandom_range(0, 99);
      if (pct < ((mix == MIX_FILL) ? 85 : 55)) begin
        pct = $urandom_range(0, 99);
        if (mix == MIX_FILL || pct < 40) sz = $urandom_range(1, (mix == MIX_FILL) ? 4 : 8);
        else if (pct < 70) sz = $urandom_range(1, 64);
        else if (pct < 92) sz = $urandom_range(1, (mem_units > 0) ? mem_units : 1);
        else sz = $urandom_range(0, 4095);
        r = mk_req(OP_ALLOC, sz, $urandom_range(0, 2047));
      end else begin
        r = mk_req(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 2047));
        if (blk_n > 0 && $urandom_range(0, 99) < 85)
          r.block_address = ADDR_W'(blk_start[$urandom_range(0, blk_n - 1)]);
      end
      pend_q.push_back(r);
    end
  endtask

  initial begin
    policy = int'(POL_FIRST);
    mem_units = MEM_MAX;
    clear_memory();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);
    apb_write(ADDR_POLICY, 32'(POL_FIRST));
    apb_write(ADDR_MEM, MEM_MAX);

    // edge sizes, unknown address, merges on each side
    pend_q.push_back(mk_req(OP_ALLOC, 1, 0));
    pend_q.push_back(mk_req(OP_ALLOC, 2048, 0));
    pend_q.push_back(mk_req(OP_ALLOC, 0, 0));
    pend_q.push_back(mk_req(OP_ALLOC, 4095, 2047));
    pend_q.push_back(mk_req(OP_ALLOC, 2047, 0));
    pend_q.push_back(mk_req(OP_ALLOC, 1, 0));
    pend_q.push_back(mk_req(OP_FREE, 0, 0));
    pend_q.push_back(mk_req(OP_FREE, 4095, 2047));
    pend_q.push_back(mk_req(OP_FREE, 0, 1));
    pend_q.push_back(mk_req(OP_ALLOC, 2048, 0));
    pend_q.push_back(mk_req(OP_FREE, 0, 0));
    pend_q.push_back(mk_req(OP_ALLOC, 10, 0));
    pend_q.push_back(mk_req(OP_ALLOC, 20, 0));
    pend_q.push_back(mk_req(OP_ALLOC, 30, 0));
    pend_q.push_back(mk_req(OP_FREE, 0, 10));
    pend_q.push_back(mk_req(OP_FREE, 0, 0));
    pend_q.push_back(mk_req(OP_FREE, 0, 30));
    pend_q.push_back(mk_req(OP_FREE, 0, 1024));
    wait_idle();

    apb_write(ADDR_POLICY, 32'(POL_BEST));  apb_write(ADDR_MEM, 2048);
    random_phase(160, MIX_NORMAL); wait_idle();
    apb_write(ADDR_POLICY, 32'(POL_WORST)); apb_write(ADDR_MEM, 300);
    random_phase(160, MIX_NORMAL); wait_idle();
    apb_write(ADDR_POLICY, 32'(POL_FIRST)); apb_write(ADDR_MEM, 1);
    random_phase(60, MIX_NORMAL);  wait_idle();
    apb_write(ADDR_POLICY, 3);              apb_write(ADDR_MEM, 2048);
    random_phase(160, MIX_NORMAL); wait_idle();
    apb_write(ADDR_POLICY, 32'(POL_BEST));  apb_write(ADDR_MEM, 0);
    random_phase(40, MIX_NORMAL);  wait_idle();
    apb_write(ADDR_POLICY, 32'(POL_WORST)); apb_write(ADDR_MEM, 4095);
    random_phase(180, MIX_NORMAL); wait_idle();
    // mostly small allocations so the block table runs full
    apb_write(ADDR_POLICY, 32'(POL_FIRST)); apb_write(ADDR_MEM, 2048);
    random_phase(390, MIX_FILL);   wait_idle();

    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fpha_pkg.sv
rtl/fpha_cell.sv
rtl/fpha_row.sv
rtl/fit_policy_hole_allocator_top.sv
bench/tb_fit_policy_hole_allocator_top.sv
